// ----- design/lic_pkg.sv -----
package lic_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_VIEW_SIZE      = 2'd0;
  localparam logic [1:0] REG_MAX_ENTRIES    = 2'd1;
  localparam logic [1:0] REG_SOURCE_ENABLED = 2'd2;

  // Field widths fixed by the interface.
  localparam int INDEX_W  = 32;
  localparam int HANDLE_W = 64;
  localparam int LIMIT_W  = 5;

  // Reset values of the configuration registers.
  localparam logic [INDEX_W-1:0] VIEW_SIZE_RST   = '0;
  localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RST = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_req;
    logic lookup;
    logic update;
    logic load_out;
  } lic_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } lic_stat_t;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_DONE = 4'b1000
  } lic_state_t;

endpackage

// ----- design/lic_ctrl.sv -----
module lic_ctrl
  import lic_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  lic_stat_t stat,
  output lic_cmd_t  cmd
);

  lic_state_t state_r, state_nxt;

  // Next-state logic: accept, look up, update, then hand off the result.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_LOOK;
      end
      ST_LOOK: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands to the datapath; nothing is taken while reset is held.
  assign in_tready     = rst_n && (state_r == ST_IDLE);
  assign cmd.latch_req = rst_n && (state_r == ST_IDLE) && in_tvalid;
  assign cmd.lookup    = (state_r == ST_LOOK);
  assign cmd.update    = (state_r == ST_UPD);
  assign cmd.load_out  = (state_r == ST_DONE) && stat.out_free;

endmodule

// ----- design/lic_dpath.sv -----
module lic_dpath
  import lic_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_addr,
  input  logic [INDEX_W-1:0]     cfg_wdata,
  input  logic [INDEX_W+HANDLE_W-1:0] in_tdata,
  input  logic                   in_tuser,
  output logic [HANDLE_W-1:0]    out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  lic_cmd_t               cmd,
  output lic_stat_t              stat
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  // Configuration registers.
  logic [INDEX_W-1:0] view_size_r;
  logic [LIMIT_W-1:0] max_entries_r;
  logic               src_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_size_r   <= VIEW_SIZE_RST;
      max_entries_r <= MAX_ENTRIES_RST;
      src_en_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_VIEW_SIZE:      view_size_r   <= cfg_wdata;
        REG_MAX_ENTRIES:    max_entries_r <= cfg_wdata[LIMIT_W-1:0];
        REG_SOURCE_ENABLED: src_en_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Request registers.
  logic [INDEX_W-1:0]  idx_r;
  logic [HANDLE_W-1:0] fill_r;
  logic                present_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      idx_r     <= in_tdata[INDEX_W-1:0];
      fill_r    <= in_tdata[INDEX_W+HANDLE_W-1:INDEX_W];
      present_r <= in_tuser;
    end
  end

  // Entry state: valid bits, tags and ages sit in flops for the parallel compare.
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [INDEX_W-1:0]  tag_r [CAPACITY];
  logic [AW-1:0]       age_r [CAPACITY];
  logic [AW-1:0]       age_nxt [CAPACITY];
  logic [CW-1:0]       count_r, count_nxt;

  // Handle storage is a memory with a registered read port.
  logic [HANDLE_W-1:0] data_mem [CAPACITY];
  logic [HANDLE_W-1:0] mem_q_r;

  // Lookup: parallel tag compare, oldest-entry match and first free slot.
  logic [CAPACITY-1:0] hit_vec, old_vec;
  logic [AW-1:0]       hit_idx, hit_age, old_idx, free_idx;
  logic [AW-1:0]       oldest_age;
  logic [LW-1:0]       limit;
  logic                bounds_err, evict;

  assign oldest_age = AW'(count_r - CW'(1));

  always_comb begin
    hit_idx  = '0;
    hit_age  = '0;
    old_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i] = valid_r[i] && (tag_r[i] == idx_r);
      old_vec[i] = valid_r[i] && (age_r[i] == oldest_age);
      if (hit_vec[i]) begin
        hit_idx = hit_idx | AW'(i);
        hit_age = hit_age | age_r[i];
      end
      if (old_vec[i]) old_idx = old_idx | AW'(i);
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = AW'(i);
    end
  end

  // Entry limit clamped to one .. CAPACITY.
  always_comb begin
    limit = LW'(max_entries_r);
    if (limit == '0) limit = LW'(1);
    if (limit > LW'(CAPACITY)) limit = LW'(CAPACITY);
  end

  assign bounds_err = (idx_r >= view_size_r) || !src_en_r;
  assign evict      = (LW'(count_r) >= limit);

  // Lookup results.
  logic [CAPACITY-1:0] hit_vec_r;
  logic                hit_r, err_r, evict_r;
  logic [AW-1:0]       hit_idx_r, hit_age_r, old_idx_r, slot_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_vec_r <= '0;
    end else if (cmd.lookup) begin
      hit_vec_r <= bounds_err ? '0 : hit_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r      <= !bounds_err && (|hit_vec);
      err_r      <= bounds_err || (!(|hit_vec) && !present_r);
      evict_r    <= evict;
      hit_idx_r  <= hit_idx;
      hit_age_r  <= hit_age;
      old_idx_r  <= old_idx;
      slot_idx_r <= evict ? old_idx : free_idx;
    end
  end

  // Update: age shuffle on a hit, eviction and insert on a filled miss.
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) age_nxt[i] = age_r[i];
    if (cmd.update && !err_r) begin
      if (hit_r) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (valid_r[i] && (age_r[i] < hit_age_r)) age_nxt[i] = age_r[i] + AW'(1);
        end
        age_nxt[hit_idx_r] = '0;
      end else begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (valid_r[i]) age_nxt[i] = age_r[i] + AW'(1);
        end
        if (evict_r) valid_nxt[old_idx_r] = 1'b0;
        else         count_nxt = count_r + CW'(1);
        valid_nxt[slot_idx_r] = 1'b1;
        age_nxt[slot_idx_r]   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < CAPACITY; i++) age_r[i] <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < CAPACITY; i++) age_r[i] <= age_nxt[i];
    end
  end

  // Tag write and handle memory access.
  always_ff @(posedge clk) begin
    if (cmd.update && !err_r && !hit_r) begin
      tag_r[slot_idx_r]    <= idx_r;
      data_mem[slot_idx_r] <= fill_r;
    end
    mem_q_r <= data_mem[hit_idx_r];
  end

  // Output register; it frees as soon as the sink takes the item.
  logic [HANDLE_W-1:0] out_data_r;
  logic [1:0]          out_user_r;
  logic                out_valid_r;

  assign stat.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= err_r ? '0 : (hit_r ? mem_q_r : fill_r);
      out_user_r <= {err_r, hit_r && !err_r};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  // Valid tags are distinct, so at most one entry can match.
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec_r)) else $error("more than one entry hit");

  // The fill count tracks the valid bits exactly.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r)) else $error("fill count out of step");

  // The cache never holds more than its capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= CAPACITY) else $error("fill count above capacity");

  // An error result carries a zero handle and no hit flag.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out && err_r |=> (out_data_r == '0) && (out_user_r[0] == 1'b0))
    else $error("error result not cleared");

endmodule

// ----- design/lru_item_cache.sv -----
// Channel  | Ports                     | Contents (lowest bit first)
// in       | in_tvalid/in_tready       | tdata: row_index[31:0], fill_handle[95:32];
//          |                           | tuser: fill_present
// out      | out_tvalid/out_tready     | tdata: item_handle[63:0]; tuser: was_hit, status
// cfg      | cfg_we/cfg_addr/cfg_wdata | 0 view_size, 1 max_entries, 2 source_enabled
//
// Each item goes through accept, tag lookup, state update with the handle
// memory read, and the load into the output register, in that order.
// The registered read of the handle memory sets the update-to-result step.
// The next item is accepted while the previous result waits in the output register.
// A stalled output holds the controller in its last step until the register frees.
// Sync reset (rst_n low) resets valid bits, ages, count, output valid and config.
module lru_item_cache
  import lic_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_addr,
  input  logic [INDEX_W-1:0]          cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [INDEX_W+HANDLE_W-1:0] in_tdata,   // row_index, fill_handle
  input  logic                        in_tuser,   // fill_present
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [HANDLE_W-1:0]         out_tdata,  // item_handle
  output logic [1:0]                  out_tuser   // was_hit, status
);

  lic_cmd_t  cmd;
  lic_stat_t stat;

  lic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lic_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import lic_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 16;
  localparam int PHASES = 17;
  localparam int PHASE_ITEMS = 100;

  // Result of one lookup as the cache should report it.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                hit;
    logic                status;
  } lookup_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [1:0]                  cfg_addr = REG_VIEW_SIZE;
  logic [INDEX_W-1:0]          cfg_wdata = '0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [INDEX_W+HANDLE_W-1:0] in_tdata = '0;   // row_index, fill_handle
  logic                        in_tuser = 1'b0; // fill_present
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [HANDLE_W-1:0]         out_tdata;       // item_handle
  logic [1:0]                  out_tuser;       // was_hit, status

  lru_item_cache u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Shadow copy of the configuration registers.
  logic [INDEX_W-1:0] view_size_q = VIEW_SIZE_RST;
  logic [LIMIT_W-1:0] max_entries_q = MAX_ENTRIES_RST;
  logic               source_en_q = 1'b0;

  // Shadow copy of the cache contents.
  logic                entry_used [ENTRIES] = '{default: 1'b0};
  logic [INDEX_W-1:0]  entry_row [ENTRIES] = '{default: '0};
  logic [HANDLE_W-1:0] entry_handle [ENTRIES] = '{default: '0};
  logic [3:0]          entry_rank [ENTRIES] = '{default: '0};

  lookup_result_t pending_results[$];
  int error_count = 0;
  int items_sent = 0;
  int hit_count = 0;
  int fill_count = 0;
  int reject_count = 0;
  int evict_count = 0;
  int phase_count = 0;
  bit gaps_on = 1'b0;
  int ready_stall = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Applies one request to the shadow cache and returns the result it should give.
  function automatic lookup_result_t lru_access(input logic [INDEX_W-1:0] row,
                                                input logic [HANDLE_W-1:0] fill,
                                                input logic present);
    lookup_result_t res;
    int count;
    int hit_slot;
    int oldest;
    int slot;
    int limit;
    logic [3:0] hit_rank;
    res.handle = '0;
    res.hit = 1'b0;
    res.status = 1'b1;
    if (row >= view_size_q || !source_en_q) begin
      reject_count++;
      return res;
    end
    count = 0;
    hit_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (entry_used[i]) begin
        count++;
        if (entry_row[i] == row) hit_slot = i;
      end
    end
    // A hit moves the entry to the front and ages the ones that were newer.
    if (hit_slot >= 0) begin
      hit_rank = entry_rank[hit_slot];
      for (int i = 0; i < ENTRIES; i++) begin
        if (entry_used[i] && entry_rank[i] < hit_rank) entry_rank[i]++;
      end
      entry_rank[hit_slot] = '0;
      res.handle = entry_handle[hit_slot];
      res.hit = 1'b1;
      res.status = 1'b0;
      hit_count++;
      return res;
    end
    if (!present) begin
      reject_count++;
      return res;
    end
    // Clamp the entry limit to 1 .. ENTRIES and evict the oldest when at the limit.
    limit = (max_entries_q == 0) ? 1 : (max_entries_q > ENTRIES) ? ENTRIES : max_entries_q;
    if (count >= limit) begin
      oldest = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (entry_used[i] && (oldest < 0 || entry_rank[i] > entry_rank[oldest])) oldest = i;
      end
      if (oldest >= 0) begin
        entry_used[oldest] = 1'b0;
        evict_count++;
      end
    end
    // Age every remaining entry and put the new one in the first free slot.
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (entry_used[i]) entry_rank[i]++;
      else if (slot < 0) slot = i;
    end
    if (slot >= 0) begin
      entry_used[slot] = 1'b1;
      entry_row[slot] = row;
      entry_handle[slot] = fill;
      entry_rank[slot] = '0;
    end
    res.handle = fill;
    res.status = 1'b0;
    fill_count++;
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sends one item and records its expected result once it is accepted.
  task automatic send_item(input logic [INDEX_W-1:0] row, input logic [HANDLE_W-1:0] fill,
                           input logic present);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {fill, row};
    in_tuser <= present;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(lru_access(row, fill, present));
    items_sent++;
  endtask

  // Stops the input and waits until every result is back and the pipeline is empty.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [INDEX_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (addr)
      REG_VIEW_SIZE:      view_size_q = data;
      REG_MAX_ENTRIES:    max_entries_q = data[LIMIT_W-1:0];
      REG_SOURCE_ENABLED: source_en_q = data[0];
      default: ;
    endcase
  endtask

  // Result checker with its own random back-pressure.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: item_handle %h tuser %b", out_tdata, out_tuser);
        error_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_tdata !== want.handle) begin
          $error("item_handle: expected %h, got %h", want.handle, out_tdata);
          error_count++;
        end
        if (out_tuser[0] !== want.hit) begin
          $error("was_hit: expected %b, got %b", want.hit, out_tuser[0]);
          error_count++;
        end
        if (out_tuser[1] !== want.status) begin
          $error("status: expected %b, got %b", want.status, out_tuser[1]);
          error_count++;
        end
      end
    end
    if (ready_stall > 0) begin
      ready_stall--;
      out_tready <= 1'b0;
    end else begin
      ready_stall = pick_gap();
      out_tready <= (ready_stall == 0);
    end
  end

  // Out of reset nothing is reachable: no view and no source.
  task automatic test_after_reset();
    send_item('0, 64'h0123_4567_89ab_cdef, 1'b1);
    wait_idle();
    write_reg(REG_SOURCE_ENABLED, 32'd1);
    send_item('0, 64'h0123_4567_89ab_cdef, 1'b1);
    wait_idle();
  endtask

  // Index range edges and the source switch.
  task automatic test_bounds();
    write_reg(REG_VIEW_SIZE, 32'd100);
    send_item(32'd99, 64'haaaa_5555_aaaa_5555, 1'b1);
    send_item(32'd100, 64'h1, 1'b1);
    send_item(32'hffff_ffff, 64'h2, 1'b1);
    send_item(32'd0, 64'h5555_aaaa_5555_aaaa, 1'b1);
    wait_idle();
    write_reg(REG_SOURCE_ENABLED, 32'd0);
    send_item(32'd99, 64'h3, 1'b1);
    wait_idle();
    write_reg(REG_SOURCE_ENABLED, 32'd1);
    send_item(32'd99, 64'h4, 1'b1);
    wait_idle();
    write_reg(REG_VIEW_SIZE, 32'hffff_ffff);
    send_item(32'hffff_fffe, '1, 1'b1);
    wait_idle();
  endtask

  // Missing fill with a nonzero handle, a stored zero handle, and a hit without fill.
  task automatic test_fill_cases();
    send_item(32'd5, 64'hdead_beef_cafe_f00d, 1'b0);
    send_item(32'd5, '0, 1'b1);
    send_item(32'd5, 64'hdead_beef_cafe_f00d, 1'b0);
    wait_idle();
  endtask

  // Eviction at a small limit, a lowered limit, clamped limits and a shrunk view.
  task automatic test_eviction();
    write_reg(REG_MAX_ENTRIES, 32'd4);
    send_item(32'd10, 64'h10, 1'b1);
    send_item(32'd11, 64'h11, 1'b1);
    send_item(32'd99, 64'h99, 1'b1);
    send_item(32'd5, 64'h5, 1'b1);
    wait_idle();
    write_reg(REG_MAX_ENTRIES, 32'd2);
    send_item(32'd20, 64'h20, 1'b1);
    send_item(32'd21, 64'h21, 1'b1);
    wait_idle();
    write_reg(REG_MAX_ENTRIES, 32'd0);
    send_item(32'd30, 64'h30, 1'b1);
    send_item(32'd30, 64'h31, 1'b1);
    wait_idle();
    write_reg(REG_MAX_ENTRIES, 32'd31);
    write_reg(REG_VIEW_SIZE, 32'd8);
    send_item(32'd30, 64'h32, 1'b1);
    send_item(32'd7, 64'h7, 1'b1);
    wait_idle();
  endtask

  // Random phases: a fresh setting each phase, then traffic over a small set of rows.
  task automatic test_random_traffic();
    logic [INDEX_W-1:0] rows [24];
    logic [INDEX_W-1:0] view;
    logic [INDEX_W-1:0] row;
    int pool;
    int r;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      r = $urandom_range(0, 9);
      if (r == 0) view = '0;
      else if (r < 3) view = '1;
      else if (r < 7) view = $urandom_range(1, 64);
      else view = $urandom;
      write_reg(REG_VIEW_SIZE, view);
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(REG_MAX_ENTRIES, 32'd0);
      else if (r == 1) write_reg(REG_MAX_ENTRIES, 32'd1);
      else if (r == 2) write_reg(REG_MAX_ENTRIES, 32'd16);
      else if (r == 3) write_reg(REG_MAX_ENTRIES, $urandom_range(17, 31));
      else write_reg(REG_MAX_ENTRIES, $urandom_range(1, 16));
      write_reg(REG_SOURCE_ENABLED, 32'($urandom_range(0, 9) != 0));
      gaps_on = ($urandom_range(0, 3) != 0);
      pool = $urandom_range(2, 24);
      for (int i = 0; i < pool; i++) rows[i] = (view != 0) ? $urandom % view : $urandom;
      phase_count++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 75) row = rows[$urandom_range(0, pool - 1)];
        else if (r < 82) row = view - 1;
        else if (r < 86) row = view;
        else row = $urandom;
        send_item(row, {$urandom, $urandom}, ($urandom_range(0, 9) != 0));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gaps_on = 1'b1;
    test_after_reset();
    test_bounds();
    test_fill_cases();
    test_eviction();
    test_random_traffic();
    repeat (8) @(posedge clk);
    $display("Sent %0d items: %0d hits, %0d fills, %0d rejected, %0d evictions.",
             items_sent, hit_count, fill_count, reject_count, evict_count);
    $display("Random traffic ran over %0d register settings with mixed stalls.", phase_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- lru_item_cache.f -----
design/lic_pkg.sv
design/lic_ctrl.sv
design/lic_dpath.sv
design/lru_item_cache.sv
tb/sv/testbench.sv
